>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the checker files.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every sampled edge.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

>>> hw/rtl/gsfp_pkg.sv
// ----------------------------------------------------------------------------
// gsfp_pkg
// Types, frame byte offsets and decode constants for the frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gsfp_pkg;

    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;

    // byte offsets inside a frame (length byte is offset 0)
    localparam logic [4:0] POS_SEQ     = 5'd2;
    localparam logic [4:0] POS_INFO    = 5'd7;
    localparam logic [4:0] POS_GEST_LO = 5'd10;
    localparam logic [4:0] POS_GEST_HI = 5'd11;
    localparam logic [4:0] POS_GEST_TP = 5'd13;
    localparam logic [4:0] POS_TOUCH_LO = 5'd14;
    localparam logic [4:0] POS_TOUCH_HI = 5'd15;
    localparam logic [4:0] POS_TCOUNT  = 5'd16;
    localparam logic [4:0] POS_WHEEL   = 5'd18;
    localparam logic [4:0] POS_X_LO    = 5'd20;
    localparam logic [4:0] POS_X_HI    = 5'd21;
    localparam logic [4:0] POS_Y_LO    = 5'd22;
    localparam logic [4:0] POS_Y_HI    = 5'd23;
    localparam logic [4:0] POS_Z_LO    = 5'd24;
    localparam logic [4:0] POS_Z_HI    = 5'd25;
    localparam logic [4:0] POS_SAT     = 5'd31;

    localparam logic [15:0] SWIPE_MASK = 16'h60FC;
    localparam logic [7:0]  SEQ_RESET  = 8'h00;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_start;
    } in_t;

    typedef struct packed {
        logic [7:0]  swipe_code;
        logic [5:0]  touch_code;
        logic [6:0]  tap_code;
        logic [7:0]  double_tap_code;
        logic [5:0]  wheel_value;
        logic        position_valid;
        logic [15:0] position_x;
        logic [15:0] position_y;
        logic [15:0] position_z;
        logic [7:0]  touch_count;
        logic [2:0]  gesture_count;
    } out_t;

    // one classified beat handed from the front to the back
    typedef struct packed {
        logic       clear;
        logic       take;
        logic       emit;
        logic [4:0] pos;
        logic [7:0] data;
    } cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/gsfp_fifo.sv
// ----------------------------------------------------------------------------
// gsfp_fifo
// Small register queue with push/full and pop/empty; push and pop may coincide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsfp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rdata,
    output logic                  empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gsfp_front.sv
// ----------------------------------------------------------------------------
// gsfp_front
// Frame tracker: byte position, length countdown, sequence check, classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsfp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire gsfp_pkg::in_t item,
    output logic               cmd_valid,
    output gsfp_pkg::cmd_t     cmd
);

    logic [7:0] pos_reg, pos_next;
    logic [7:0] rem_reg, rem_next;
    logic [7:0] seq_reg, seq_next;
    logic       drop_reg, drop_next;
    logic [7:0] b;

    assign b = item.frame_byte;

    always_comb
    begin
        pos_next  = pos_reg;
        rem_next  = rem_reg;
        seq_next  = seq_reg;
        drop_next = drop_reg;
        cmd_valid = 1'b0;
        cmd       = '0;
        cmd.data  = b;
        if (accept)
        begin
            if (item.frame_start)
            begin
                pos_next  = '0;
                rem_next  = (b > 8'd1) ? b - 8'd1 : 8'd0;
                drop_next = 1'b0;
                cmd_valid = 1'b1;
                cmd.clear = 1'b1;
                cmd.emit  = (b <= 8'd1);
            end
            else if (rem_reg != '0)
            begin
                pos_next = pos_reg + 8'd1;
                rem_next = rem_reg - 8'd1;
                if (!drop_reg && pos_next == {3'b000, gsfp_pkg::POS_SEQ})
                begin
                    if (b == seq_reg)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        seq_next = b;
                    end
                end
                cmd_valid = !drop_reg;
                cmd.take  = 1'b1;
                cmd.emit  = (rem_next == '0) && !drop_next;
                cmd.pos   = (pos_next > {3'b000, gsfp_pkg::POS_SAT}) ? gsfp_pkg::POS_SAT
                                                                      : pos_next[4:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            rem_reg  <= '0;
            seq_reg  <= gsfp_pkg::SEQ_RESET;
            drop_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            rem_reg  <= rem_next;
            seq_reg  <= seq_next;
            drop_reg <= drop_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gsfp_back.sv
// ----------------------------------------------------------------------------
// gsfp_back
// Field decoder: applies classified beats to the frame fields, builds results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gsfp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    input  wire gsfp_pkg::cmd_t cmd,
    output logic                cmd_pop,
    input  wire logic           res_full,
    output logic                res_push,
    output gsfp_pkg::out_t      res
);

    logic [1:0]  info_reg, info_next;
    logic [15:0] gather_reg, gather_next;
    logic [7:0]  swipe_reg, swipe_next;
    logic [5:0]  touch_reg, touch_next;
    logic [6:0]  tap_reg, tap_next;
    logic [7:0]  dtap_reg, dtap_next;
    logic [5:0]  wheel_reg, wheel_next;
    logic [47:0] posw_reg, posw_next;
    logic [7:0]  tcount_reg, tcount_next;
    logic [2:0]  gcount_reg, gcount_next;
    logic        reach_reg, reach_next;
    logic        fire;
    logic [15:0] w;
    logic [7:0]  b;

    assign b        = cmd.data;
    assign cmd_pop  = cmd_valid && !(cmd.emit && res_full);
    assign fire     = cmd_pop;
    assign res_push = fire && cmd.emit;
    assign w        = {b, gather_reg[7:0]};

    always_comb
    begin
        info_next   = info_reg;
        gather_next = gather_reg;
        swipe_next  = swipe_reg;
        touch_next  = touch_reg;
        tap_next    = tap_reg;
        dtap_next   = dtap_reg;
        wheel_next  = wheel_reg;
        posw_next   = posw_reg;
        tcount_next = tcount_reg;
        gcount_next = gcount_reg;
        reach_next  = reach_reg;
        if (cmd.clear)
        begin
            info_next   = '0;
            gather_next = '0;
            swipe_next  = '0;
            touch_next  = '0;
            tap_next    = '0;
            dtap_next   = '0;
            wheel_next  = '0;
            posw_next   = '0;
            tcount_next = '0;
            gcount_next = '0;
            reach_next  = 1'b0;
        end
        if (cmd.take)
        begin
            if (cmd.pos == gsfp_pkg::POS_Z_HI)
            begin
                reach_next = 1'b1;
            end
            unique case (cmd.pos)
                gsfp_pkg::POS_INFO:
                begin
                    info_next = b[1:0];
                end
                gsfp_pkg::POS_GEST_LO, gsfp_pkg::POS_TOUCH_LO:
                begin
                    gather_next = {8'h00, b};
                end
                gsfp_pkg::POS_GEST_HI:
                begin
                    gather_next = {b, gather_reg[7:0]};
                end
                gsfp_pkg::POS_GEST_TP:
                begin
                    // bit 31 of the gesture word is bit 7 of this byte
                    if (!b[7] && ((gather_reg & gsfp_pkg::SWIPE_MASK) != '0))
                    begin
                        swipe_next  = swipe_reg | {1'b1, gather_reg[8:2]};
                        gcount_next = gcount_reg + 3'd1;
                    end
                    gather_next = '0;
                end
                gsfp_pkg::POS_TOUCH_HI:
                begin
                    gather_next = w;
                    if (w[4:0] != '0)
                    begin
                        touch_next = touch_reg | {1'b1, w[4:0]};
                    end
                    if (w[9:5] != '0)
                    begin
                        tap_next = tap_reg | {2'b10, w[9:5]};
                    end
                    if (w[14:10] != '0)
                    begin
                        dtap_next = dtap_reg | {3'b100, w[14:10]};
                    end
                    gcount_next = gcount_reg + 3'(w[4:0] != '0) + 3'(w[9:5] != '0)
                                + 3'(w[14:10] != '0);
                end
                gsfp_pkg::POS_TCOUNT:
                begin
                    tcount_next = b;
                    gather_next = '0;
                end
                gsfp_pkg::POS_WHEEL:
                begin
                    if (info_reg[1])
                    begin
                        wheel_next  = 6'(b[4:0]) + 6'd1;
                        gcount_next = gcount_reg + 3'd1;
                    end
                end
                gsfp_pkg::POS_X_LO:
                begin
                    if (info_reg[0]) posw_next[7:0] = b;
                end
                gsfp_pkg::POS_X_HI:
                begin
                    if (info_reg[0]) posw_next[15:8] = b;
                end
                gsfp_pkg::POS_Y_LO:
                begin
                    if (info_reg[0]) posw_next[23:16] = b;
                end
                gsfp_pkg::POS_Y_HI:
                begin
                    if (info_reg[0]) posw_next[31:24] = b;
                end
                gsfp_pkg::POS_Z_LO:
                begin
                    if (info_reg[0]) posw_next[39:32] = b;
                end
                gsfp_pkg::POS_Z_HI:
                begin
                    if (info_reg[0]) posw_next[47:40] = b;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        res.swipe_code      = swipe_next;
        res.touch_code      = touch_next;
        res.tap_code        = tap_next;
        res.double_tap_code = dtap_next;
        res.wheel_value     = wheel_next;
        res.position_valid  = info_next[0] && reach_next;
        res.position_x      = posw_next[15:0];
        res.position_y      = posw_next[31:16];
        res.position_z      = posw_next[47:32];
        res.touch_count     = tcount_next;
        res.gesture_count   = gcount_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            info_reg   <= '0;
            gather_reg <= '0;
            swipe_reg  <= '0;
            touch_reg  <= '0;
            tap_reg    <= '0;
            dtap_reg   <= '0;
            wheel_reg  <= '0;
            posw_reg   <= '0;
            tcount_reg <= '0;
            gcount_reg <= '0;
            reach_reg  <= 1'b0;
        end
        else if (fire)
        begin
            info_reg   <= info_next;
            gather_reg <= gather_next;
            swipe_reg  <= swipe_next;
            touch_reg  <= touch_next;
            tap_reg    <= tap_next;
            dtap_reg   <= dtap_next;
            wheel_reg  <= wheel_next;
            posw_reg   <= posw_next;
            tcount_reg <= tcount_next;
            gcount_reg <= gcount_next;
            reach_reg  <= reach_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/gesture_sensor_frame_parser.sv
// One byte beat per cycle is accepted while full is low. A frame's result goes
// to the result ports through both queues: the frame tracker writes the frame's
// last beat into the beat queue at the edge that accepts it, and the field
// decoder moves it into the result queue once it is at the head and the result
// queue has room. Duplicate-sequence frames and stray bytes give no result. The
// front keeps taking beats while results wait, until the CMD_DEPTH beat queue
// fills behind a RES_DEPTH result queue that is not popped.
// ----------------------------------------------------------------------------
// gesture_sensor_frame_parser
// Top level: frame tracker, beat queue, field decoder and result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gesture_sensor_frame_parser #(
    parameter int CMD_DEPTH = gsfp_pkg::CMD_DEPTH,
    parameter int RES_DEPTH = gsfp_pkg::RES_DEPTH
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire gsfp_pkg::in_t  item,
    output logic                empty,
    input  wire logic           pop,
    output gsfp_pkg::out_t      result
);

    localparam int CMD_W = $bits(gsfp_pkg::cmd_t);
    localparam int RES_W = $bits(gsfp_pkg::out_t);

    logic           accept;
    logic           f_cmd_valid;
    gsfp_pkg::cmd_t f_cmd;
    gsfp_pkg::cmd_t q_cmd;
    logic           q_empty;
    logic           b_pop;
    logic           r_full;
    logic           r_push;
    gsfp_pkg::out_t b_res;
    logic [CMD_W-1:0] q_cmd_bits;
    logic [RES_W-1:0] r_bits;

    assign accept = push && !full;
    assign q_cmd  = gsfp_pkg::cmd_t'(q_cmd_bits);
    assign result = gsfp_pkg::out_t'(r_bits);

    gsfp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cmd_valid (f_cmd_valid),
        .cmd       (f_cmd)
    );

    gsfp_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_cmd_valid),
        .wdata (CMD_W'(f_cmd)),
        .full  (full),
        .pop   (b_pop),
        .rdata (q_cmd_bits),
        .empty (q_empty)
    );

    gsfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (q_cmd),
        .cmd_pop   (b_pop),
        .res_full  (r_full),
        .res_push  (r_push),
        .res       (b_res)
    );

    gsfp_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (r_push),
        .wdata (RES_W'(b_res)),
        .full  (r_full),
        .pop   (pop),
        .rdata (r_bits),
        .empty (empty)
    );

endmodule

`default_nettype wire

>>> hw/rtl/gsfp_checker.sv
// ----------------------------------------------------------------------------
// gsfp_checker
// Port-level checks on the result stream of the frame parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gsfp_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           full,
    input wire logic           empty,
    input wire logic           pop,
    input wire gsfp_pkg::out_t result
);

    logic res_wait;
    logic ranges_ok;
    logic marks_ok;
    logic codes_clear;

    assign res_wait  = !empty && !pop;
    assign ranges_ok = (result.wheel_value <= 6'd32) && (result.gesture_count <= 3'd5);
    assign marks_ok  = (result.swipe_code == '0 || result.swipe_code[7])
                    && (result.touch_code == '0 || result.touch_code[5])
                    && (result.tap_code == '0 || result.tap_code[6])
                    && (result.double_tap_code == '0 || result.double_tap_code[7]);
    assign codes_clear = (result.swipe_code == '0) && (result.touch_code == '0)
                      && (result.tap_code == '0) && (result.double_tap_code == '0)
                      && (result.wheel_value == '0);

    // waiting result holds until popped
    `ASSERT_NEXT(a_res_hold, res_wait, !empty && $stable(result), "waiting result changed")

    `ASSERT_IMPLY(a_ranges, !empty, ranges_ok, "wheel or gesture count out of range")

    `ASSERT_IMPLY(a_code_marks, !empty, marks_ok, "code without its marker bit")

    // no items counted means no codes and no wheel
    `ASSERT_IMPLY(a_count_zero, !empty && result.gesture_count == '0, codes_clear, "codes with zero count")

    `ASSERT_ALWAYS(a_no_x, !$isunknown({full, empty}), "handshake flag unknown")

endmodule

bind gesture_sensor_frame_parser gsfp_checker u_gsfp_checker (.*);

`default_nettype wire

>>> tb/gesture_sensor_frame_parser_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesture_sensor_frame_parser_checker
// Watches the byte queue and the result queue of the frame parser, tracks
// each frame as its beats go in, and compares every decoded result field by
// field with the oldest frame still owed.
// ----------------------------------------------------------------------------

module gesture_sensor_frame_parser_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic           full,
    input  gsfp_pkg::in_t  item,
    input  logic           empty,
    input  logic           pop,
    input  gsfp_pkg::out_t result,
    output int             mismatches,
    output int             frames_waiting,
    output int             frames_predicted,
    output int             frames_checked,
    output int             frames_dropped,
    output int             beats_taken
);
    import gsfp_pkg::*;

    // frame tracking state
    logic [7:0]  byte_idx;
    logic [7:0]  left_in_frame;
    logic [7:0]  last_seq;
    logic        repeat_seq;
    logic [1:0]  info;
    logic [15:0] gather;
    out_t        frame_acc;
    out_t        owed_frames[$];

    int errors;
    int predicted;
    int checked;
    int dropped;
    int beats;

    task automatic report_mismatch(input string what);
        errors++;
        $display("[%0t] parser check: %s", $time, what);
    endtask

    task automatic compare_field(input string name, input logic [15:0] got,
                                 input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s got %0h expected %0h",
                                      checked, name, got, want));
    endtask

    function void clear_frame();
        byte_idx      = 8'd0;
        left_in_frame = 8'd0;
        repeat_seq    = 1'b0;
        info          = 2'b00;
        gather        = 16'd0;
        frame_acc     = '0;
    endfunction

    function void count_gesture();
        if (frame_acc.gesture_count != 3'd7)
            frame_acc.gesture_count = frame_acc.gesture_count + 3'd1;
    endfunction

    task automatic decode_byte(input logic [7:0] p, input logic [7:0] b);
        logic [31:0] w;
        w = 32'd0;
        case (p)
            POS_SEQ:
                if (b == last_seq)
                    repeat_seq = 1'b1;
                else
                    last_seq = b;
            POS_INFO:
                info = b[1:0];
            POS_GEST_LO, POS_TOUCH_LO:
                gather = {8'd0, b};
            POS_GEST_HI:
                gather[15:8] = b;
            POS_GEST_TP:
            begin
                // byte 12 is reserved and never lands in the word
                w = {b, 8'd0, gather};
                if (!w[31] && (w[15:0] & SWIPE_MASK) != 16'd0)
                begin
                    frame_acc.swipe_code = w[9:2] | 8'h80;
                    count_gesture();
                end
            end
            POS_TOUCH_HI:
            begin
                w = {16'd0, b, gather[7:0]};
                if (w[4:0] != 5'd0)
                begin
                    frame_acc.touch_code = 6'h20 | {1'b0, w[4:0]};
                    count_gesture();
                end
                if (w[9:5] != 5'd0)
                begin
                    frame_acc.tap_code = 7'h40 | {2'b00, w[9:5]};
                    count_gesture();
                end
                if (w[14:10] != 5'd0)
                begin
                    frame_acc.double_tap_code = 8'h80 | {3'b000, w[14:10]};
                    count_gesture();
                end
            end
            POS_TCOUNT:
                frame_acc.touch_count = b;
            POS_WHEEL:
                if (info[1])
                begin
                    frame_acc.wheel_value = {1'b0, b[4:0]} + 6'd1;
                    count_gesture();
                end
            POS_X_LO: if (info[0]) frame_acc.position_x[7:0]  = b;
            POS_X_HI: if (info[0]) frame_acc.position_x[15:8] = b;
            POS_Y_LO: if (info[0]) frame_acc.position_y[7:0]  = b;
            POS_Y_HI: if (info[0]) frame_acc.position_y[15:8] = b;
            POS_Z_LO: if (info[0]) frame_acc.position_z[7:0]  = b;
            POS_Z_HI: if (info[0]) frame_acc.position_z[15:8] = b;
            default: ;
        endcase
    endtask

    task automatic owe_frame();
        out_t r;
        r = frame_acc;
        r.position_valid = info[0] && (byte_idx >= {3'd0, POS_Z_HI});
        owed_frames.push_back(r);
        predicted++;
    endtask

    task automatic track_beat(input in_t beat);
        if (beat.frame_start)
        begin
            // a start inside an open frame just throws the old one away
            clear_frame();
            left_in_frame = (beat.frame_byte > 8'd1) ? beat.frame_byte - 8'd1 : 8'd0;
            if (left_in_frame == 8'd0)
                owe_frame();
        end
        else if (left_in_frame != 8'd0)
        begin
            byte_idx      = byte_idx + 8'd1;
            left_in_frame = left_in_frame - 8'd1;
            if (!repeat_seq)
                decode_byte(byte_idx, beat.frame_byte);
            if (left_in_frame == 8'd0)
            begin
                if (repeat_seq)
                    dropped++;
                else
                    owe_frame();
            end
        end
    endtask

    task automatic check_frame(input out_t got);
        out_t want;
        if (owed_frames.size() == 0)
        begin
            report_mismatch($sformatf("result %h arrived with no frame owed", got));
            return;
        end
        want = owed_frames.pop_front();
        compare_field("swipe_code", got.swipe_code, want.swipe_code);
        compare_field("touch_code", got.touch_code, want.touch_code);
        compare_field("tap_code", got.tap_code, want.tap_code);
        compare_field("double_tap_code", got.double_tap_code, want.double_tap_code);
        compare_field("wheel_value", got.wheel_value, want.wheel_value);
        compare_field("position_valid", got.position_valid, want.position_valid);
        compare_field("position_x", got.position_x, want.position_x);
        compare_field("position_y", got.position_y, want.position_y);
        compare_field("position_z", got.position_z, want.position_z);
        compare_field("touch_count", got.touch_count, want.touch_count);
        compare_field("gesture_count", got.gesture_count, want.gesture_count);
        checked++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_frame();
            last_seq = SEQ_RESET;
            owed_frames.delete();
        end
        else
        begin
            // results come from older beats, so check before tracking this edge's beat
            if (pop && !empty)
                check_frame(result);
            if (push && !full)
            begin
                beats++;
                track_beat(item);
            end
        end
        mismatches       <= errors;
        frames_waiting   <= owed_frames.size();
        frames_predicted <= predicted;
        frames_checked   <= checked;
        frames_dropped   <= dropped;
        beats_taken      <= beats;
    end

endmodule

>>> tb/gesture_sensor_frame_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesture_sensor_frame_parser_tb
// Feeds sensor frames byte by byte into the parser: a few hand-built frames
// for the corner cases, then random frames of varied length, repeated and
// fresh sequence numbers, aborted frames and stray bytes, with random gaps
// and back-pressure on both sides. Checking lives in the checker module.
// ----------------------------------------------------------------------------

module gesture_sensor_frame_parser_tb;
    import gsfp_pkg::*;

    localparam int BEAT_TARGET  = 850;
    localparam int CALM_AFTER   = 720;
    localparam int HOLD_CYCLES  = 80;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 8;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    in_t  item = '0;
    logic full;
    logic empty;
    out_t result;

    int mismatches;
    int frames_waiting;
    int frames_predicted;
    int frames_checked;
    int frames_dropped;
    int beats_taken;

    logic       calm = 1'b0;
    logic       hold_req = 1'b0;
    int         send_idle_pct = 15;
    int         pop_idle_pct = 20;
    int         beats_sent = 0;
    int         stall_cycles = 0;
    logic [7:0] seq_seen = SEQ_RESET;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    gesture_sensor_frame_parser DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    gesture_sensor_frame_parser_checker parse_check (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .item             (item),
        .empty            (empty),
        .pop              (pop),
        .result           (result),
        .mismatches       (mismatches),
        .frames_waiting   (frames_waiting),
        .frames_predicted (frames_predicted),
        .frames_checked   (frames_checked),
        .frames_dropped   (frames_dropped),
        .beats_taken      (beats_taken)
    );

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                stall_cycles <= 0;
            else if (stall_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
                $display("** gesture_sensor_frame_parser: FAILED **");
                $finish;
            end
            else
                stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!calm && $urandom_range(0, 99) < pop_idle_pct)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic push_beat(input logic [7:0] b, input logic s);
        in_t beat;
        int  gap;
        beat.frame_byte  = b;
        beat.frame_start = s;
        gap = 0;
        if (!calm && $urandom_range(0, 99) < send_idle_pct)
            gap = $urandom_range(1, 13);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        item <= beat;
        @(posedge clk);
        while (full)
            @(posedge clk);
        beats_sent++;
    endtask

    function automatic logic [7:0] field_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r < 2)
            return 8'h00;
        if (r == 2)
            return 8'hFF;
        return 8'($urandom);
    endfunction

    // count below len aborts the frame, above len adds stray bytes after it
    task automatic send_frame(input int len, input int count, input logic [7:0] seq);
        logic [7:0] b;
        for (int i = 0; i < count; i++)
        begin
            if (i == 0)
                b = len[7:0];
            else if (i == POS_SEQ)
                b = seq;
            else
                b = field_byte();
            push_beat(b, i == 0);
        end
        if (len > POS_SEQ && count > POS_SEQ && seq != seq_seen)
            seq_seen = seq;
    endtask

    task automatic random_frame();
        int         len;
        int         count;
        int         pick;
        logic [7:0] seq;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            len = POS_Z_HI + 1;
        else if (pick < 66)
            len = $urandom_range(3, POS_Z_HI);
        else if (pick < 86)
            len = $urandom_range(POS_Z_HI + 2, 34);
        else if (pick < 96)
            len = $urandom_range(0, 2);
        else
            len = $urandom_range(35, 255);
        count = (len > 1) ? len : 1;
        pick = $urandom_range(0, 99);
        if (pick < 10 && len > 1)
            count = $urandom_range(1, len - 1);
        else if (pick < 18)
            count = count + $urandom_range(1, 3);
        // one in ten frames repeats the sequence number; it is dropped if it reaches that byte
        if ($urandom_range(0, 9) == 0)
            seq = seq_seen;
        else
            seq = seq_seen + 8'($urandom_range(1, 255));
        send_frame(len, count, seq);
    endtask

    initial
    begin
        int         frame_no;
        logic [7:0] b;
        frame_no = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // sequence number equal to the reset value: dropped
        send_frame(3, 3, SEQ_RESET);
        // length 0 and 1 end at the length byte with an all-zero result
        push_beat(8'd0, 1'b1);
        push_beat(8'd1, 1'b1);
        push_beat(8'hFF, 1'b0);
        // opened, then abandoned by the next start
        send_frame(20, 4, 8'h01);
        // ends at the touch word: swipe and all three touch kinds, no position
        for (int i = 0; i < 16; i++)
        begin
            case (i)
                0:            b = 8'd16;
                POS_SEQ:      b = 8'hFF;
                POS_GEST_LO:  b = 8'hFC;
                POS_GEST_HI:  b = 8'h60;
                POS_TOUCH_LO: b = 8'hFF;
                POS_TOUCH_HI: b = 8'h7F;
                default:      b = 8'h00;
            endcase
            push_beat(b, i == 0);
        end
        seq_seen = 8'hFF;

        while (beats_sent < BEAT_TARGET)
        begin
            if (beats_sent >= CALM_AFTER)
                calm = 1'b1;
            if (frame_no % 8 == 0)
            begin
                send_idle_pct = $urandom_range(0, 3) * 20;
                pop_idle_pct  = $urandom_range(0, 3) * 20;
            end
            if (frame_no == 12)
            begin
                // receiver holds off while short frames keep coming: queues fill
                send_idle_pct = 0;
                hold_req = 1'b1;
                for (int i = 0; i < 16; i++)
                    push_beat(8'($urandom_range(0, 1)), 1'b1);
            end
            random_frame();
            frame_no++;
        end

        push <= 1'b0;
        @(posedge clk);
        while (frames_waiting != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d beats in %0d frames, %0d dropped on a repeated sequence",
                 beats_taken, frame_no, frames_dropped);
        $display("%0d decoded results compared, %0d mismatches", frames_checked, mismatches);
        if (mismatches == 0 && frames_waiting == 0)
            $display("** gesture_sensor_frame_parser: PASSED **");
        else
            $display("** gesture_sensor_frame_parser: FAILED **");
        $finish;
    end

endmodule

>>> gesture_sensor_frame_parser.f
+incdir+hw/rtl
hw/rtl/gsfp_pkg.sv
hw/rtl/gsfp_fifo.sv
hw/rtl/gsfp_front.sv
hw/rtl/gsfp_back.sv
hw/rtl/gesture_sensor_frame_parser.sv
hw/rtl/gsfp_checker.sv
tb/gesture_sensor_frame_parser_checker.sv
tb/gesture_sensor_frame_parser_tb.sv
